// ===== rtl/core/bmg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmg_pkg;

  // Fraction bits of the log2 result and bits of the square root
  localparam int unsigned LOG_FRAC_BITS = 28;
  localparam int unsigned ROOT_BITS     = 32;
  localparam int unsigned TAYLOR_TERMS  = 6;

  // round(2 ln 2 * 2^30) and floor(pi * 2^30)
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;

  localparam logic [63:0] TWO_POW32 = 64'h1_0000_0000;

  // Taylor divisors n*(n-1) and their floor(2^32 / d) reciprocals
  localparam logic [7:0] DIV_COS [TAYLOR_TERMS] =
    '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [7:0] DIV_SIN [TAYLOR_TERMS] =
    '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] RCP_COS [TAYLOR_TERMS] = '{
    32'(TWO_POW32 / 64'd2),  32'(TWO_POW32 / 64'd12), 32'(TWO_POW32 / 64'd30),
    32'(TWO_POW32 / 64'd56), 32'(TWO_POW32 / 64'd90), 32'(TWO_POW32 / 64'd132)};
  localparam logic [31:0] RCP_SIN [TAYLOR_TERMS] = '{
    32'(TWO_POW32 / 64'd6),  32'(TWO_POW32 / 64'd20),  32'(TWO_POW32 / 64'd42),
    32'(TWO_POW32 / 64'd72), 32'(TWO_POW32 / 64'd110), 32'(TWO_POW32 / 64'd156)};

  // Output saturation bounds
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MEAN   = 2'd0,
    REG_SPREAD = 2'd1,
    REG_REJECT = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/core/box_muller_gaussian_pair_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Box-Muller Gaussian pair generator.
// Input stream: one word per cycle holds two uniform 0.32 fractions; the first
// sets the radius sqrt(-2 ln u1), the second the angle 2*pi*u2. Output stream:
// one word holds the cosine and sine samples in Q16.16, each scaled by spread
// and offset by mean, with tuser flagging saturation of either sample.
// A first uniform at or below reject_limit yields no output word.
// Configuration: cfg_we_i writes register cfg_addr_i (0 mean, 1 spread,
// 2 reject_limit) at the clock edge; write only while the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled. Between the
// accepting edge and m_axis_tvalid_o a word passes the 28 squaring stages of
// the log2, the 32 bit-per-stage root, then the product and rounding stages.
// A stall on the output freezes the whole pipeline; s_axis_tready_o follows
// !m_axis_tvalid_o | m_axis_tready_i, so no word is lost or repeated.
// Reset clears all valid bits and loads mean 0, spread 1.0, reject_limit 43.
module box_muller_gaussian_pair_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] uniform_a, [63:32] uniform_b
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] sample_cos, [63:32] sample_sin
  output logic             m_axis_tuser_o,   // [0] clipped
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned LOGB  = bmg_pkg::LOG_FRAC_BITS;
  localparam int unsigned RB    = bmg_pkg::ROOT_BITS;
  localparam int unsigned NT    = bmg_pkg::TAYLOR_TERMS;
  // Stage numbers (stage 0 is the input register)
  localparam int unsigned ROOT_STAGE = 1 + LOGB + 1 + 2 + RB;
  localparam int unsigned ROT_STAGE  = 2 + 3 * NT + 1;
  localparam int unsigned ANG_DELAY  = ROOT_STAGE - ROT_STAGE;
  localparam int unsigned NSTG       = ROOT_STAGE + 3;

  typedef struct packed {
    logic [29:0] x2;
    logic [32:0] acc_c;
    logic [32:0] acc_s;
    logic [30:0] trm_c;
    logic [30:0] trm_s;
    logic [30:0] quo_c;
    logic [30:0] quo_s;
    logic        neg;
    logic [1:0]  quad;
  } tay_t;

  typedef struct packed {
    logic [31:0] cmag;
    logic        cneg;
    logic [31:0] smag;
    logic        sneg;
  } trig_t;

  logic en;

  // Configuration registers
  logic [31:0] mean_q;
  logic [23:0] spread_q;
  logic [15:0] reject_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      spread_q <= 24'd65536;
      reject_q <= 16'd43;
    end else if (cfg_we_i) begin
      case (bmg_pkg::reg_idx_e'(cfg_addr_i))
        bmg_pkg::REG_MEAN:   mean_q   <= cfg_wdata_i;
        bmg_pkg::REG_SPREAD: spread_q <= cfg_wdata_i[23:0];
        bmg_pkg::REG_REJECT: reject_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Valid chain: advance as one with the payload
  logic [NSTG-1:0] vld_q;
  logic            out_vld_q;
  logic            take;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign take = s_axis_tvalid_i && (s_axis_tdata_i[31:0] > 32'(reject_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTG-2:0], take};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  // Stage 0: input register
  logic [31:0] ua_q, ub_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua_q <= s_axis_tdata_i[31:0];
      ub_q <= s_axis_tdata_i[63:32];
    end
  end

  // ---------------- Radius path ----------------

  // Normalize u1 so its top bit lands at bit 31
  logic [4:0]  nrm_e_d, nrm_e_q;
  logic [31:0] nrm_y_d, nrm_y_q;

  always_comb begin
    nrm_e_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (ua_q[b]) nrm_e_d = 5'(b);
    end
    nrm_y_d = ua_q << (5'd31 - nrm_e_d);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_e_q <= nrm_e_d;
      nrm_y_q <= nrm_y_d;
    end
  end

  // log2 fraction: one squaring per stage, one result bit each
  logic [31:0]     lg_y_q [LOGB];
  logic [LOGB-1:0] lg_f_q [LOGB];
  logic [4:0]      lg_e_q [LOGB];

  for (genvar k = 0; k < LOGB; k++) begin : g_log
    logic [31:0]     y_in;
    logic [LOGB-1:0] f_in;
    logic [4:0]      e_in;
    logic [63:0]     sq;
    logic [32:0]     sh;

    if (k == 0) begin : g_first
      assign y_in = nrm_y_q;
      assign f_in = '0;
      assign e_in = nrm_e_q;
    end else begin : g_next
      assign y_in = lg_y_q[k-1];
      assign f_in = lg_f_q[k-1];
      assign e_in = lg_e_q[k-1];
    end

    assign sq = 64'(y_in) * 64'(y_in);
    assign sh = sq[63:31];

    always_ff @(posedge clk_i) begin
      if (en) begin
        lg_y_q[k] <= sh[32] ? sh[32:1] : sh[31:0];
        lg_f_q[k] <= {f_in[LOGB-2:0], sh[32]};
        lg_e_q[k] <= e_in;
      end
    end
  end

  // -log2(u1) in Q6.28
  logic [33:0] t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= 34'h2_0000_0000 - 34'({lg_e_q[LOGB-1], lg_f_q[LOGB-1]});
    end
  end

  // r^2 = t * 2 ln 2, split into two partial products
  logic [47:0] pp_lo_q, pp_hi_q;
  logic [63:0] r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_lo_q <= 48'(t_q[16:0]) * 48'(bmg_pkg::TWO_LN2_Q30);
      pp_hi_q <= 48'(t_q[33:17]) * 48'(bmg_pkg::TWO_LN2_Q30);
      r2_q    <= 64'(pp_lo_q) + (64'(pp_hi_q) << 17);
    end
  end

  // Square root: one root bit per stage, top bit first
  logic [RB-1:0] sq_root_q [RB];
  logic [63:0]   sq_rem_q  [RB-1];

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    localparam int B = RB - 1 - i;
    logic [RB-1:0] root_in;
    logic [63:0]   rem_in;
    logic [64:0]   trial;
    logic          fit;

    if (i == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = r2_q;
    end else begin : g_next
      assign root_in = sq_root_q[i-1];
      assign rem_in  = sq_rem_q[i-1];
    end

    assign trial = (65'(root_in) << (B + 1)) + (65'd1 << (2 * B));
    assign fit   = 65'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_root_q[i] <= fit ? (root_in | (RB'(1) << B)) : root_in;
      end
    end

    if (i < RB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_rem_q[i] <= fit ? 64'(65'(rem_in) - trial) : rem_in;
        end
      end
    end
  end

  // ---------------- Angle path ----------------

  // Fold the angle into one quadrant: |a| and its sign, quadrant count
  logic [32:0] ang_sum;
  logic [29:0] ang_d, amag;
  logic [62:0] xprod;
  logic [29:0] ax_x_q;
  logic        ax_neg_q;
  logic [1:0]  ax_quad_q;

  assign ang_sum = 33'(ub_q) + 33'h2000_0000;
  assign ang_d   = ang_sum[29:0];
  assign amag    = ang_d[29] ? (ang_d - 30'h2000_0000) : (30'h2000_0000 - ang_d);
  assign xprod   = 63'(amag) * 63'(bmg_pkg::PI_Q30) + 63'h4000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_x_q    <= xprod[60:31];
      ax_neg_q  <= !ang_d[29];
      ax_quad_q <= ang_sum[31:30];
    end
  end

  // x squared, rounded
  logic [59:0] x2prod;
  tay_t        tay_init_q;

  assign x2prod = 60'(ax_x_q) * 60'(ax_x_q) + 60'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tay_init_q.x2    <= x2prod[59:30];
      tay_init_q.acc_c <= 33'h0_4000_0000;
      tay_init_q.acc_s <= 33'(ax_x_q);
      tay_init_q.trm_c <= 31'h4000_0000;
      tay_init_q.trm_s <= 31'(ax_x_q);
      tay_init_q.quo_c <= '0;
      tay_init_q.quo_s <= '0;
      tay_init_q.neg   <= ax_neg_q;
      tay_init_q.quad  <= ax_quad_q;
    end
  end

  // Taylor terms: multiply, reciprocal divide, correct and accumulate
  tay_t tay_a_q [NT];
  tay_t tay_b_q [NT];
  tay_t tay_c_q [NT];

  for (genvar j = 0; j < NT; j++) begin : g_tay
    tay_t        t_in, a_d, b_d, c_d;
    logic [60:0] pc, ps;
    logic [62:0] qc, qs;
    logic [30:0] rem_c, rem_s, term_c, term_s;

    if (j == 0) begin : g_first
      assign t_in = tay_init_q;
    end else begin : g_next
      assign t_in = tay_c_q[j-1];
    end

    assign pc = 61'(t_in.trm_c) * 61'(t_in.x2);
    assign ps = 61'(t_in.trm_s) * 61'(t_in.x2);

    always_comb begin
      a_d       = t_in;
      a_d.trm_c = pc[60:30];
      a_d.trm_s = ps[60:30];
    end

    assign qc = 63'(tay_a_q[j].trm_c) * 63'(bmg_pkg::RCP_COS[j]);
    assign qs = 63'(tay_a_q[j].trm_s) * 63'(bmg_pkg::RCP_SIN[j]);

    always_comb begin
      b_d       = tay_a_q[j];
      b_d.quo_c = qc[62:32];
      b_d.quo_s = qs[62:32];
    end

    always_comb begin
      c_d    = tay_b_q[j];
      rem_c  = tay_b_q[j].trm_c - 31'(39'(tay_b_q[j].quo_c) * 39'(bmg_pkg::DIV_COS[j]));
      rem_s  = tay_b_q[j].trm_s - 31'(39'(tay_b_q[j].quo_s) * 39'(bmg_pkg::DIV_SIN[j]));
      term_c = (rem_c >= 31'(bmg_pkg::DIV_COS[j])) ? tay_b_q[j].quo_c + 31'd1
                                                   : tay_b_q[j].quo_c;
      term_s = (rem_s >= 31'(bmg_pkg::DIV_SIN[j])) ? tay_b_q[j].quo_s + 31'd1
                                                   : tay_b_q[j].quo_s;
      c_d.trm_c = term_c;
      c_d.trm_s = term_s;
      if (j % 2 == 0) begin
        c_d.acc_c = tay_b_q[j].acc_c - 33'(term_c);
        c_d.acc_s = tay_b_q[j].acc_s - 33'(term_s);
      end else begin
        c_d.acc_c = tay_b_q[j].acc_c + 33'(term_c);
        c_d.acc_s = tay_b_q[j].acc_s + 33'(term_s);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        tay_a_q[j] <= a_d;
        tay_b_q[j] <= b_d;
        tay_c_q[j] <= c_d;
      end
    end
  end

  // Apply the angle sign and rotate by the quadrant
  logic [32:0] rc, rs, cv, sv, cabs, sabs;
  trig_t       rot_d, rot_q;

  always_comb begin
    rc = tay_c_q[NT-1].acc_c;
    rs = tay_c_q[NT-1].neg ? -tay_c_q[NT-1].acc_s : tay_c_q[NT-1].acc_s;
    case (tay_c_q[NT-1].quad)
      2'd0: begin
        cv = rc;
        sv = rs;
      end
      2'd1: begin
        cv = -rs;
        sv = rc;
      end
      2'd2: begin
        cv = -rc;
        sv = -rs;
      end
      default: begin
        cv = rs;
        sv = -rc;
      end
    endcase
    cabs       = cv[32] ? -cv : cv;
    sabs       = sv[32] ? -sv : sv;
    rot_d.cmag = cabs[31:0];
    rot_d.cneg = cv[32];
    rot_d.smag = sabs[31:0];
    rot_d.sneg = sv[32];
  end

  always_ff @(posedge clk_i) begin
    if (en) rot_q <= rot_d;
  end

  // Hold the trig values until the root is ready
  trig_t dl_q [ANG_DELAY];

  for (genvar k = 0; k < ANG_DELAY; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) dl_q[k] <= (k == 0) ? rot_q : dl_q[(k == 0) ? 0 : k - 1];
    end
  end

  // ---------------- Sample stages ----------------

  logic [31:0] mag_in [2];
  logic        neg_in [2];
  logic [63:0] m1_q   [2];
  logic        m1_neg_q [2];
  logic [58:0] m2_q   [2];
  logic        m2_neg_q [2];
  logic [31:0] smp_d  [2];
  logic        sat_d  [2];
  logic [31:0] out_cos_q, out_sin_q;
  logic        out_clip_q;

  assign mag_in[0] = dl_q[ANG_DELAY-1].cmag;
  assign neg_in[0] = dl_q[ANG_DELAY-1].cneg;
  assign mag_in[1] = dl_q[ANG_DELAY-1].smag;
  assign neg_in[1] = dl_q[ANG_DELAY-1].sneg;

  for (genvar b = 0; b < 2; b++) begin : g_smp
    logic [63:0] p_rnd;
    logic [59:0] s_rnd;
    logic [33:0] mval, sum;

    assign p_rnd = m1_q[b] + 64'h1000_0000;
    assign s_rnd = 60'(m2_q[b]) + 60'h2000_0000;

    always_comb begin
      mval     = 34'(s_rnd[59:30]);
      sum      = (m2_neg_q[b] ? -mval : mval) + {{2{mean_q[31]}}, mean_q};
      sat_d[b] = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);
      if (!sat_d[b]) begin
        smp_d[b] = sum[31:0];
      end else if (sum[33]) begin
        smp_d[b] = bmg_pkg::SAT_MIN;
      end else begin
        smp_d[b] = bmg_pkg::SAT_MAX;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        m1_q[b]     <= 64'(sq_root_q[RB-1]) * 64'(mag_in[b]);
        m1_neg_q[b] <= neg_in[b];
        m2_q[b]     <= 59'(p_rnd[63:29]) * 59'(spread_q);
        m2_neg_q[b] <= m1_neg_q[b];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cos_q  <= smp_d[0];
      out_sin_q  <= smp_d[1];
      out_clip_q <= sat_d[0] || sat_d[1];
    end
  end

  assign m_axis_tdata_o = {out_sin_q, out_cos_q};
  assign m_axis_tuser_o = out_clip_q;

endmodule

`default_nettype wire

// ===== rtl/core/bmg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  // Hold an unaccepted output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word dropped or changed under stall");

  // Input side opens exactly when the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // Stall on the input while the output word waits
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // A clipped word carries a saturated sample
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[31:0] == bmg_pkg::SAT_MAX) ||
      (m_axis_tdata_o[31:0] == bmg_pkg::SAT_MIN) ||
      (m_axis_tdata_o[63:32] == bmg_pkg::SAT_MAX) ||
      (m_axis_tdata_o[63:32] == bmg_pkg::SAT_MIN))
    else $error("clip flag without a saturated sample");

endmodule

bind box_muller_gaussian_pair_core bmg_checker u_bmg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [31:0] sample_cos;
    logic [31:0] sample_sin;
    logic        clipped;
  } gauss_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_tdata = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [63:0] m_tdata;
  wire         m_tuser;

  box_muller_gaussian_pair_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Predictor copy of the registers
  longint      mean_q = 0;
  logic [23:0] spread_q = 24'd65536;
  logic [15:0] reject_q = 16'd43;

  logic [63:0] uniform_pending [$];
  gauss_pair_t expected_pairs [$];
  int unsigned send_idle = 34;
  int unsigned recv_idle = 62;
  bit          stall_req = 1'b0;
  bit          stall_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // -log2(m * 2^-32) in Q6.28
  function automatic longint unsigned neg_log2_q28(logic [31:0] m);
    int unsigned e;
    longint unsigned y, f;
    e = 31;
    f = 0;
    while (e > 0 && m[e] == 1'b0) e--;
    y = ({32'd0, m} << (31 - e)) & 64'hFFFF_FFFF;
    for (int i = 0; i < bmg_pkg::LOG_FRAC_BITS; i++) begin
      y = (y * y) >> 31;
      f = f << 1;
      if (y >= 64'h1_0000_0000) begin
        f = f | 64'd1;
        y = y >> 1;
      end
    end
    return (64'd32 << bmg_pkg::LOG_FRAC_BITS) -
           ((longint'(e) << bmg_pkg::LOG_FRAC_BITS) + f);
  endfunction

  function automatic void cos_sin_q30(input longint unsigned x, output longint c,
                                      output longint s);
    longint unsigned x2, tc, ts, nc, ns;
    x2 = (x * x + 64'd536870912) >> 30;
    tc = 64'd1 << 30;
    ts = x;
    c = longint'(tc);
    s = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      nc = 64'(2 * k);
      ns = 64'(2 * k + 1);
      tc = ((tc * x2) >> 30) / (nc * (nc - 1));
      ts = ((ts * x2) >> 30) / (ns * (ns - 1));
      if (k % 2 == 1) begin
        c = c - longint'(tc);
        s = s - longint'(ts);
      end else begin
        c = c + longint'(tc);
        s = s + longint'(ts);
      end
    end
  endfunction

  // Scale by radius and spread, add mean, saturate
  function automatic logic [31:0] scale_sample(longint unsigned r, longint trig, ref bit clip);
    bit neg;
    longint unsigned mag, p;
    longint v;
    neg = trig < 0;
    mag = neg ? longint'(-trig) : longint'(trig);
    p = (r * mag + (64'd1 << 28)) >> 29;
    p = (p * {40'd0, spread_q} + (64'd1 << 29)) >> 30;
    v = neg ? -longint'(p) : longint'(p);
    v = v + mean_q;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      clip = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      clip = 1'b1;
    end
    return v[31:0];
  endfunction

  // Expected pair for one accepted word; returns 0 when rejected
  function automatic bit predict_pair(logic [63:0] w, output gauss_pair_t res);
    logic [31:0] ua;
    longint unsigned ub, r, d, x, amag;
    longint a, c, s, cv, sv;
    int unsigned q;
    bit clip;
    ua = w[31:0];
    ub = {32'd0, w[63:32]};
    clip = 1'b0;
    res = '0;
    if (ua <= {16'd0, reject_q}) return 1'b0;
    r = int_sqrt(neg_log2_q28(ua) * {33'd0, bmg_pkg::TWO_LN2_Q30});
    d = (ub + (64'd1 << 29)) & 64'h3FFF_FFFF;
    q = 32'(((ub + (64'd1 << 29)) >> 30) & 64'd3);
    a = longint'(d) - (64'sd1 <<< 29);
    amag = a < 0 ? longint'(-a) : longint'(a);
    x = (amag * {32'd0, bmg_pkg::PI_Q30} + (64'd1 << 30)) >> 31;
    cos_sin_q30(x, c, s);
    if (a < 0) s = -s;
    case (q)
      0: begin cv = c;  sv = s;  end
      1: begin cv = -s; sv = c;  end
      2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
    res.sample_cos = scale_sample(r, cv, clip);
    res.sample_sin = scale_sample(r, sv, clip);
    res.clipped = clip;
    return 1'b1;
  endfunction

  // Drive input words from the pending queue, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    gauss_pair_t exp_pair;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_valid && s_tready) begin
        if (predict_pair(s_tdata, exp_pair)) expected_pairs.push_back(exp_pair);
      end
      if (!s_valid || s_tready) begin
        if (uniform_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_valid <= 1'b1;
          s_tdata <= uniform_pending.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random idling, plus a long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left <= 400;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    gauss_pair_t want;
    if (rst_ni && m_tvalid && m_ready) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected output word %h", m_tdata);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        if (m_tdata[31:0] !== want.sample_cos) begin
          $error("sample_cos expected %h actual %h", want.sample_cos, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== want.sample_sin) begin
          $error("sample_sin expected %h actual %h", want.sample_sin, m_tdata[63:32]);
          errors++;
        end
        if (m_tuser !== want.clipped) begin
          $error("clipped expected %b actual %b", want.clipped, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input bmg_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      bmg_pkg::REG_MEAN:   mean_q = longint'($signed(val));
      bmg_pkg::REG_SPREAD: spread_q = val[23:0];
      bmg_pkg::REG_REJECT: reject_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] mn, input logic [31:0] sp, input logic [31:0] rj);
    write_reg(bmg_pkg::REG_MEAN, mn);
    write_reg(bmg_pkg::REG_SPREAD, sp);
    write_reg(bmg_pkg::REG_REJECT, rj);
  endtask

  // Wait until every word is in and every expectation is met
  task automatic drain();
    while (uniform_pending.size() > 0 || s_valid || expected_pairs.size() > 0)
      @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned n);
    logic [31:0] ua;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: ua = $urandom_range(70000);
        1: ua = {16'd0, reject_q} + $urandom_range(3) - 1;
        2: ua = $urandom >> $urandom_range(31);
        default: ua = $urandom;
      endcase
      uniform_pending.push_back({$urandom, ua});
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset settings, rejection edges, radius extremes, quadrants
    uniform_pending.push_back({32'h0000_0000, 32'h0000_0000});
    uniform_pending.push_back({32'hFFFF_FFFF, 32'd43});
    uniform_pending.push_back({32'h0000_0000, 32'd44});
    uniform_pending.push_back({32'h2000_0000, 32'd1});
    uniform_pending.push_back({32'h4000_0000, 32'hFFFF_FFFF});
    uniform_pending.push_back({32'h8000_0000, 32'h8000_0000});
    uniform_pending.push_back({32'hC000_0000, 32'h0000_0001});
    uniform_pending.push_back({32'hFFFF_FFFF, 32'h7FFF_FFFF});
    uniform_pending.push_back({32'h1FFF_FFFF, 32'h1234_5678});
    uniform_pending.push_back({32'h5FFF_FFFF, 32'hDEAD_BEEF});
    uniform_pending.push_back({32'hE000_0000, 32'h0001_0000});
    uniform_pending.push_back({32'h6000_0000, 32'h0000_002C});
    uniform_pending.push_back({32'hA000_0000, 32'hF000_0000});
    drain();

    // Saturate high: largest mean and spread, no rejection but zero
    set_regs(32'h7FFF_FFFF, 32'h00FF_FFFF, 32'd0);
    uniform_pending.push_back({32'h0000_0000, 32'd0});
    uniform_pending.push_back({32'h4000_0000, 32'd1});
    uniform_pending.push_back({32'hC000_0000, 32'd1});
    uniform_pending.push_back({32'h8000_0000, 32'hFFFF_FFFF});
    queue_random(300);
    drain();

    send_idle = 62;
    recv_idle = 34;
    // Most negative mean, zero spread, widest rejection
    set_regs(32'h8000_0000, 32'd0, 32'h0000_FFFF);
    uniform_pending.push_back({32'h8000_0000, 32'h0001_0000});
    queue_random(300);
    drain();

    set_regs(32'h8000_0000, 32'h00FF_FFFF, 32'd100);
    queue_random(200);
    drain();

    set_regs($urandom, $urandom_range(24'hFFFFFF), $urandom_range(16'hFFFF));
    queue_random(300);
    drain();

    // No idling, with one long output hold so the input backs up
    send_idle = 0;
    recv_idle = 0;
    set_regs(32'h0000_0000, 32'd65536, 32'd43);
    queue_random(200);
    stall_req = 1'b1;
    drain();

    set_regs($urandom, $urandom_range(24'h3FFFF), $urandom_range(16'hFF));
    queue_random(300);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bmg_pkg.sv
rtl/core/box_muller_gaussian_pair_core.sv
rtl/core/bmg_checker.sv
tb/tb.sv
